// ----- rtl/core/virtqueue_chain_publisher_macros.svh -----
// assertion macros for the virtqueue chain publisher checker
`ifndef VIRTQUEUE_CHAIN_PUBLISHER_MACROS_SVH
`define VIRTQUEUE_CHAIN_PUBLISHER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VQCP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define VQCP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/vqcp_pkg.sv -----
// types and constants shared by the virtqueue chain publisher
`timescale 1ns / 1ps
package vqcp_pkg;

	localparam logic RK_IN_CHAIN = 1'b0;
	localparam logic RK_IN_POLL  = 1'b1;

	localparam logic [1:0] RK_DESC  = 2'd0;
	localparam logic [1:0] RK_AVAIL = 2'd1;
	localparam logic [1:0] RK_POLL  = 2'd2;

	localparam int FLAG_NEXT_BIT  = 0;
	localparam int FLAG_WRITE_BIT = 1;

	typedef struct packed {
		logic        kind;
		logic [63:0] buf_addr;
		logic [31:0] buf_len;
		logic        device_writes;
		logic        last_entry;
		logic [15:0] used_idx;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [14:0] slot;
		logic [63:0] desc_addr;
		logic [31:0] desc_len;
		logic [1:0]  desc_flags;
		logic [14:0] next_slot;
		logic [14:0] head_slot;
		logic [15:0] new_avail_idx;
		logic        ready_res;
		logic        last_result;
	} rsp_t;

	// results of one item: the second one is used only on a closing entry
	typedef struct packed {
		logic two;
		rsp_t r0;
		rsp_t r1;
	} rsp_pair_t;

endpackage

// ----- rtl/core/vqcp_in_stage.sv -----
// input register stage of the virtqueue chain publisher
`timescale 1ns / 1ps
module vqcp_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  vqcp_pkg::req_t req,
	input  logic          take,
	output logic          valid_s1,
	output vqcp_pkg::req_t item_s1
);
	import vqcp_pkg::*;

	logic vld_s1;

	assign req_ready = !vld_s1 || take;
	assign valid_s1  = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end
endmodule

// ----- rtl/core/vqcp_engine.sv -----
// ring index state and result generation for one item
`timescale 1ns / 1ps
module vqcp_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  logic               valid_s1,
	input  vqcp_pkg::req_t     item_s1,
	input  logic               room,
	output logic               take,
	output vqcp_pkg::rsp_pair_t pair
);
	import vqcp_pkg::*;

	logic [3:0]  qlog2_q;
	logic [15:0] next_free_q;
	logic [15:0] avail_idx_q;
	logic [15:0] last_used_q;
	logic [14:0] chain_head_q;
	logic        in_chain_q;

	logic [15:0] mask;
	logic [15:0] nf_inc;
	logic [15:0] ai_inc;
	logic [14:0] desc_slot;
	logic [14:0] head;
	logic        done_ready;

	assign take = valid_s1 && room;

	always_comb begin
		mask       = (16'd1 << qlog2_q) - 16'd1;
		nf_inc     = next_free_q + 16'd1;
		ai_inc     = avail_idx_q + 16'd1;
		desc_slot  = 15'(next_free_q & mask);
		head       = in_chain_q ? chain_head_q : desc_slot;
		done_ready = item_s1.used_idx != last_used_q;

		pair = '0;
		if (item_s1.kind == RK_IN_POLL) begin
			pair.r0.result_kind = RK_POLL;
			pair.r0.last_result = 1'b1;
			pair.r0.ready_res   = done_ready;
			pair.r0.slot        = done_ready ? 15'(last_used_q & mask) : 15'd0;
		end else begin
			pair.r0.result_kind = RK_DESC;
			pair.r0.slot        = desc_slot;
			pair.r0.desc_addr   = item_s1.buf_addr;
			pair.r0.desc_len    = item_s1.buf_len;
			pair.r0.desc_flags[FLAG_NEXT_BIT]  = !item_s1.last_entry;
			pair.r0.desc_flags[FLAG_WRITE_BIT] = item_s1.device_writes;
			pair.r0.next_slot   = item_s1.last_entry ? 15'd0 : 15'(nf_inc & mask);
			// closing entry also publishes the head in the avail ring
			pair.two               = item_s1.last_entry;
			pair.r1.result_kind    = RK_AVAIL;
			pair.r1.slot           = 15'(avail_idx_q & mask);
			pair.r1.head_slot      = head;
			pair.r1.new_avail_idx  = ai_inc;
			pair.r1.last_result    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlog2_q      <= 4'd8;
			next_free_q  <= '0;
			avail_idx_q  <= '0;
			last_used_q  <= '0;
			chain_head_q <= '0;
			in_chain_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				qlog2_q <= cfg_wdata;
			end
			if (take) begin
				if (item_s1.kind == RK_IN_POLL) begin
					if (done_ready) begin
						last_used_q <= last_used_q + 16'd1;
					end
				end else begin
					next_free_q <= nf_inc;
					if (item_s1.last_entry) begin
						avail_idx_q  <= ai_inc;
						chain_head_q <= '0;
						in_chain_q   <= 1'b0;
					end else begin
						chain_head_q <= head;
						in_chain_q   <= 1'b1;
					end
				end
			end
		end
	end
endmodule

// ----- rtl/core/vqcp_out_stage.sv -----
// result register with a pending slot for the second result of a closing entry
`timescale 1ns / 1ps
module vqcp_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vqcp_pkg::rsp_pair_t pair,
	output logic                room,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output vqcp_pkg::rsp_t      rsp
);
	import vqcp_pkg::*;

	logic out_valid_q;
	logic pend_valid_q;
	rsp_t out_q;
	rsp_t pend_q;
	logic out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign room      = out_free && !pend_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= pair.two;
		end else if (pend_valid_q && out_free) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q  <= pair.r0;
			pend_q <= pair.r1;
		end else if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end
	end
endmodule

// ----- rtl/core/virtqueue_chain_publisher.sv -----
// top level of the split virtqueue driver-side chain publisher
`timescale 1ns / 1ps
// usage:
// req carries one item per transfer: a chain entry (buffer address, length,
// device-writes and last flags) or a poll carrying the device's used index.
// rsp carries results: a descriptor write per chain entry, plus an avail
// publish after it when the entry closes the chain; a poll gives one answer.
// cfg_we/cfg_wdata write the ring size as log2 (reset 8); write it only idle.
// an item taken from req passes through the input register and the result
// register before its first result appears on rsp. throughput: one item per
// cycle while rsp_ready is high; a closing entry holds the engine while its
// second result waits in the pending slot of the output stage.
// when the receiver stalls, the result register holds and the input register
// fills, after which req_ready drops; nothing is lost or repeated.
// reset clears all ring indexes, the open chain and every stage's valid bits.
module virtqueue_chain_publisher (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_wdata,
	input  logic           req_valid,
	output logic           req_ready,
	input  vqcp_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output vqcp_pkg::rsp_t rsp
);
	import vqcp_pkg::*;

	logic      valid_s1;
	req_t      item_s1;
	logic      take;
	logic      room;
	rsp_pair_t pair;

	vqcp_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.take      (take),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	vqcp_engine u_eng (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.room      (room),
		.take      (take),
		.pair      (pair)
	);

	vqcp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.pair      (pair),
		.room      (room),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);
endmodule

// ----- rtl/core/vqcp_checker.sv -----
// port-level checks for the virtqueue chain publisher, bound to the top level
`timescale 1ns / 1ps
`include "virtqueue_chain_publisher_macros.svh"
module vqcp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input vqcp_pkg::rsp_t rsp
);
	import vqcp_pkg::*;

	`VQCP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp dropped or changed while stalled")
	`VQCP_ASSERT_IMP(a_kind_legal, rsp_valid, rsp.result_kind != 2'd3, "undefined result kind")
	`VQCP_ASSERT_IMP(a_avail_last, rsp_valid && rsp.result_kind == RK_AVAIL, rsp.last_result && rsp.desc_flags == 2'd0, "avail publish malformed")
	`VQCP_ASSERT_IMP(a_poll_idle, rsp_valid && rsp.result_kind == RK_POLL && !rsp.ready_res, rsp.slot == 15'd0, "empty poll answer carries a slot")
	`VQCP_ASSERT_IMP(a_no_next, rsp_valid && rsp.result_kind == RK_DESC && !rsp.desc_flags[FLAG_NEXT_BIT], rsp.next_slot == 15'd0, "last descriptor carries a next slot")
endmodule

bind virtqueue_chain_publisher vqcp_checker u_vqcp_checker (.*);
